// ===== rtl/core/kmdt_pkg.sv =====
// Shared constants and types of the key matrix debounce and transpose block.
`default_nettype none

package kmdt_pkg;

   localparam int NUM_ROWS  = 8;
   localparam int NUM_COLS  = 16;
   localparam int ROW_BITS  = 8;
   localparam int COL_IDX_W = 4;
   localparam int ROW_IDX_W = 3;
   localparam int KEYS_W    = 16;
   localparam int COUNT_W   = 8;

   localparam logic [COUNT_W-1:0]  RESET_SCANS = COUNT_W'(5);
   localparam logic [ROW_BITS-1:0] ROW_MASK    = ROW_BITS'((64'd1 << NUM_ROWS) - 64'd1);
   localparam logic [ROW_IDX_W-1:0] LAST_ROW   = ROW_IDX_W'(NUM_ROWS - 1);

   typedef logic [ROW_BITS-1:0] col_bits_type;

   // Matrix snapshot handed from the scan logic to the row emitter.
   typedef struct packed {
      logic                              load;
      logic                              settled;
      col_bits_type [NUM_COLS-1:0]       cols;
   } snap_type;

endpackage

`default_nettype wire

// ===== rtl/core/kmdt_scan.sv =====
// Candidate, stable matrix and countdown update for one column sample.
`default_nettype none

module kmdt_scan (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              advance,
   input  wire logic [kmdt_pkg::COL_IDX_W-1:0]    col_index,
   input  wire logic [kmdt_pkg::ROW_BITS-1:0]     sense_bits,
   input  wire logic                              scan_end,
   input  wire logic [kmdt_pkg::COUNT_W-1:0]      debounce_scans,
   output kmdt_pkg::snap_type                     snap
);

   kmdt_pkg::col_bits_type [kmdt_pkg::NUM_COLS-1:0] cand_ff, cand_in;
   kmdt_pkg::col_bits_type [kmdt_pkg::NUM_COLS-1:0] stable_ff, stable_in;
   logic [kmdt_pkg::COUNT_W-1:0]  count_ff, count_in;
   logic [kmdt_pkg::COUNT_W-1:0]  reload;
   logic [kmdt_pkg::ROW_BITS-1:0] masked;
   logic                          col_ok;

   assign masked = sense_bits & kmdt_pkg::ROW_MASK;
   assign reload = (debounce_scans == '0) ? kmdt_pkg::COUNT_W'(1) : debounce_scans;
   assign col_ok = {1'b0, col_index} < (kmdt_pkg::COL_IDX_W + 1)'(kmdt_pkg::NUM_COLS);

   always_comb begin
      cand_in   = cand_ff;
      stable_in = stable_ff;
      count_in  = count_ff;
      if (advance) begin
         if (col_ok && cand_ff[col_index] != masked) begin
            cand_in[col_index] = masked;
            count_in           = reload;
         end
         if (scan_end && count_in != '0) begin
            count_in = count_in - kmdt_pkg::COUNT_W'(1);
            // copy the whole candidate set once the countdown expires
            if (count_in == '0) begin
               stable_in = cand_in;
            end
         end
      end
   end

   assign snap.load    = advance && scan_end;
   assign snap.settled = (count_in == '0);
   assign snap.cols    = stable_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         cand_ff   <= '0;
         stable_ff <= '0;
         count_ff  <= kmdt_pkg::RESET_SCANS;
      end else begin
         cand_ff   <= cand_in;
         stable_ff <= stable_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/kmdt_emit.sv =====
// Snapshot holder that emits the stable matrix one transposed row per transaction.
`default_nettype none

module kmdt_emit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  kmdt_pkg::snap_type                     snap,
   output logic                                   free,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [kmdt_pkg::ROW_IDX_W-1:0]         rsp_row_index,
   output logic [kmdt_pkg::KEYS_W-1:0]            rsp_row_keys,
   output logic                                   rsp_settled,
   output logic                                   rsp_last_row
);

   kmdt_pkg::col_bits_type [kmdt_pkg::NUM_COLS-1:0] cols_ff;
   logic                              busy_ff;
   logic [kmdt_pkg::ROW_IDX_W-1:0]    row_ff;
   logic                              settled_ff;
   logic                              last;

   assign last = (row_ff == kmdt_pkg::LAST_ROW);
   assign free = !busy_ff || (rsp_ready && last);

   assign rsp_valid     = busy_ff;
   assign rsp_row_index = row_ff;
   assign rsp_settled   = settled_ff;
   assign rsp_last_row  = last;

   always_comb begin
      rsp_row_keys = '0;
      for (int x = 0; x < kmdt_pkg::NUM_COLS; x++) begin
         rsp_row_keys[x] = cols_ff[x][row_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         row_ff  <= '0;
      end else if (snap.load) begin
         busy_ff <= 1'b1;
         row_ff  <= '0;
      end else if (busy_ff && rsp_ready) begin
         if (last) begin
            busy_ff <= 1'b0;
         end else begin
            row_ff <= row_ff + kmdt_pkg::ROW_IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (snap.load) begin
         cols_ff    <= snap.cols;
         settled_ff <= snap.settled;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/key_matrix_debounce_transpose.sv =====
// Top level: key matrix scan with debounce and transposition into row words.
// Flow: a sample is registered in the input register on acceptance and then processed;
//   on a scan end the row emitter registers the snapshot, and the first row transaction is valid from it.
// Throughput: one column sample per cycle while no scan end waits; a scan end occupies the row emitter for
//   NUM_ROWS transactions, and a further scan end waits in the input register until then.
// Reset (synchronous): matrices clear, countdown and debounce_scans load 5, nothing pending.
`default_nettype none

module key_matrix_debounce_transpose (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [kmdt_pkg::COL_IDX_W-1:0]    req_col_index,
   input  wire logic [kmdt_pkg::ROW_BITS-1:0]     req_sense_bits,
   input  wire logic                              req_scan_end,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [kmdt_pkg::ROW_IDX_W-1:0]         rsp_row_index,
   output logic [kmdt_pkg::KEYS_W-1:0]            rsp_row_keys,
   output logic                                   rsp_settled,
   output logic                                   rsp_last_row,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [kmdt_pkg::COUNT_W-1:0]      csr_debounce_scans
);

   // input register holding one column sample
   logic                              s1_valid_ff;
   logic [kmdt_pkg::COL_IDX_W-1:0]    s1_col_ff;
   logic [kmdt_pkg::ROW_BITS-1:0]     s1_bits_ff;
   logic                              s1_scan_end_ff;
   logic                              s1_advance;

   logic [kmdt_pkg::COUNT_W-1:0]      dbs_ff;
   kmdt_pkg::snap_type                snap;
   logic                              emit_free;

   // configuration is always taken at once
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dbs_ff <= kmdt_pkg::RESET_SCANS;
      end else if (csr_valid) begin
         dbs_ff <= csr_debounce_scans;
      end
   end

   // A plain sample always advances; a scan end advances only when the emitter
   // can take a fresh snapshot (idle, or handing over its last row this cycle).
   assign s1_advance = s1_valid_ff && (!s1_scan_end_ff || emit_free);
   assign req_ready  = !s1_valid_ff || s1_advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   // hold the payload while stalled, load on each accepted transaction
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_col_ff      <= req_col_index;
         s1_bits_ff     <= req_sense_bits;
         s1_scan_end_ff <= req_scan_end;
      end
   end

   kmdt_scan u_scan (
      .clock          (clock),
      .reset          (reset),
      .advance        (s1_advance),
      .col_index      (s1_col_ff),
      .sense_bits     (s1_bits_ff),
      .scan_end       (s1_scan_end_ff),
      .debounce_scans (dbs_ff),
      .snap           (snap)
   );

   kmdt_emit u_emit (
      .clock         (clock),
      .reset         (reset),
      .snap          (snap),
      .free          (emit_free),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_row_index (rsp_row_index),
      .rsp_row_keys  (rsp_row_keys),
      .rsp_settled   (rsp_settled),
      .rsp_last_row  (rsp_last_row)
   );

`ifndef NO_ASSERTIONS
   // a new snapshot never overwrites rows still waiting to be taken
   a_snap_free : assert property (@(posedge clock) disable iff (reset)
      snap.load |-> emit_free)
      else $error("snapshot loaded while emitter busy");

   // rows of one burst follow each other in order without a gap
   a_row_order : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_row |=>
         rsp_valid && rsp_row_index == $past(rsp_row_index) + kmdt_pkg::ROW_IDX_W'(1))
      else $error("row burst out of order");

   // input stalls only behind a scan end waiting for the emitter
   a_stall_cause : assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> s1_valid_ff && s1_scan_end_ff && rsp_valid)
      else $error("input stalled without a pending scan end");
`endif

endmodule

`default_nettype wire
